FILE: rtl/core/page_access_histogram_macros.svh
// Assertion macros used by the page access histogram engine.
`ifndef PAGE_ACCESS_HISTOGRAM_MACROS_SVH
`define PAGE_ACCESS_HISTOGRAM_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define PAH_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define PAH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Property holds at every edge.
`define PAH_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`else
`define PAH_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define PAH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define PAH_ASSERT_ALWAYS(lbl, clk, rst, prop)
`endif

`endif

FILE: rtl/core/pah_pkg.sv
`timescale 1ns / 1ps
package pah_pkg;

   localparam int unsigned TABLE_ENTRIES   = 256;
   localparam int unsigned PAGE_SHIFT_BITS = 12;

   localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int unsigned USED_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned PAGE_W  = 52;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned TAG_W   = 32;
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned EUSED_W = 9;

   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned RSP_TDATA_W = 96;

   localparam logic [TAG_W-1:0]   TAG_RESET = 32'h0000_4000;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RECORD = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_HIT        = 3'd0,
      ST_INSERT     = 3'd1,
      ST_FILTER     = 3'd2,
      ST_FULL       = 3'd3,
      ST_READ_VALID = 3'd4,
      ST_READ_EMPTY = 3'd5,
      ST_CLEARED    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RD_ADDR,
      S_RD_DATA,
      S_DONE
   } state_type;

   typedef struct packed {
      func_type          func;
      logic [PAGE_W-1:0] page;
      logic              tag_match;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      logic [PAGE_W-1:0]  page;
      logic [COUNT_W-1:0] count;
   } res_type;

endpackage

FILE: rtl/core/pah_ram.sv
`timescale 1ns / 1ps
module pah_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pah_engine.sv
`timescale 1ns / 1ps
`include "page_access_histogram_macros.svh"
module pah_engine
   import pah_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_vld,
   input  cmd_type           cmd,
   output logic              cmd_rdy,
   output logic              res_vld,
   output res_type           res,
   output logic [USED_W-1:0] used,
   input  logic              res_ack
);

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   res_type                 res_ff, res_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    free_fnd_ff, free_fnd_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [USED_W-1:0]       used_ff, used_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_idx;
   logic               page_we;
   logic               count_we;
   logic [COUNT_W-1:0] count_wdata;
   logic [PAGE_W-1:0]  page_rdata;
   logic [COUNT_W-1:0] count_rdata;

   logic [COUNT_W-1:0] count_inc;
   logic               entry_hit;
   logic               free_any;
   logic [IDX_W-1:0]   free_slot;
   logic [IDX_W-1:0]   slot_idx;
   logic               slot_ok;
   logic               res_held;

   pah_ram #(.WIDTH(PAGE_W), .DEPTH(TABLE_ENTRIES)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (wr_idx),
      .wr_data (cmd_ff.page),
      .rd_addr (rd_addr),
      .rd_data (page_rdata)
   );

   pah_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_ENTRIES)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (wr_idx),
      .wr_data (count_wdata),
      .rd_addr (rd_addr),
      .rd_data (count_rdata)
   );

   // Shared compare/increment unit, one table entry per cycle.
   assign count_inc = (count_rdata == COUNT_MAX) ? count_rdata : count_rdata + 1'b1;
   assign entry_hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (page_rdata == cmd_ff.page);
   assign free_any  = free_fnd_ff || !valid_ff[cmp_idx_ff];
   assign free_slot = free_fnd_ff ? free_idx_ff : cmp_idx_ff;
   assign slot_idx  = IDX_W'(cmd_ff.slot);
   assign slot_ok   = ({{(32 - SLOT_W){1'b0}}, cmd_ff.slot} < 32'(TABLE_ENTRIES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cmp_vld_ff  <= 1'b0;
         free_fnd_ff <= 1'b0;
         valid_ff    <= '0;
         used_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         cmp_vld_ff  <= cmp_vld_in;
         free_fnd_ff <= free_fnd_in;
         valid_ff    <= valid_in;
         used_ff     <= used_in;
      end
      cmd_ff      <= cmd_in;
      res_ff      <= res_in;
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      res_in      = res_ff;
      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_vld_in  = 1'b0;
      free_idx_in = free_idx_ff;
      free_fnd_in = free_fnd_ff;
      valid_in    = valid_ff;
      used_in     = used_ff;
      rd_addr     = scan_idx_ff;
      wr_idx      = cmp_idx_ff;
      page_we     = 1'b0;
      count_we    = 1'b0;
      count_wdata = count_inc;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_vld) begin
               cmd_in      = cmd;
               scan_idx_in = '0;
               free_fnd_in = 1'b0;
               unique case (cmd.func)
                  FUNC_RECORD: state_in = S_SCAN;
                  FUNC_READ:   state_in = S_RD_ADDR;
                  FUNC_CLEAR: begin
                     valid_in = '0;
                     used_in  = '0;
                     res_in   = '{status: ST_CLEARED, page: '0, count: '0};
                     state_in = S_DONE;
                  end
                  default: begin
                     res_in   = '{status: ST_READ_EMPTY, page: '0, count: '0};
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue the next read while comparing the previous entry
            scan_idx_in = scan_idx_ff + 1'b1;
            cmp_idx_in  = scan_idx_ff;
            cmp_vld_in  = 1'b1;
            if (cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_fnd_ff) begin
               free_fnd_in = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            if (entry_hit) begin
               count_we = 1'b1;
               res_in   = '{status: ST_HIT, page: cmd_ff.page, count: count_inc};
               state_in = S_DONE;
            end else if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
               state_in = S_DONE;
               if (!cmd_ff.tag_match) begin
                  res_in = '{status: ST_FILTER, page: cmd_ff.page, count: '0};
               end else if (!free_any) begin
                  res_in = '{status: ST_FULL, page: cmd_ff.page, count: '0};
               end else begin
                  wr_idx              = free_slot;
                  page_we             = 1'b1;
                  count_we            = 1'b1;
                  count_wdata         = COUNT_W'(1);
                  valid_in[free_slot] = 1'b1;
                  used_in             = used_ff + 1'b1;
                  res_in = '{status: ST_INSERT, page: cmd_ff.page, count: COUNT_W'(1)};
               end
            end
         end

         S_RD_ADDR: begin
            rd_addr  = slot_idx;
            state_in = S_RD_DATA;
         end

         S_RD_DATA: begin
            if (slot_ok && valid_ff[slot_idx]) begin
               res_in = '{status: ST_READ_VALID, page: page_rdata, count: count_rdata};
            end else begin
               res_in = '{status: ST_READ_EMPTY, page: '0, count: '0};
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign cmd_rdy  = (state_ff == S_IDLE);
   assign res_vld  = (state_ff == S_DONE);
   assign res      = res_ff;
   assign used     = used_ff;
   assign res_held = res_vld && !res_ack;

   `PAH_ASSERT_ALWAYS(a_used_matches_valid, clock, reset, $countones(valid_ff) == int'(used_ff))
   `PAH_ASSERT_SAME(a_insert_free_slot, clock, reset, page_we, !valid_ff[wr_idx])
   `PAH_ASSERT_SAME(a_cmd_only_idle, clock, reset, cmd_vld, cmd_rdy)
   `PAH_ASSERT_NEXT(a_res_hold, clock, reset, res_held, res_vld && $stable(res_ff))

endmodule

FILE: rtl/core/page_access_histogram.sv
`timescale 1ns / 1ps
// Page access histogram: counts sampled data accesses per page.
// Request channel (req_*): tuser carries the function (record, read slot,
// clear), tdata the sample address and the slot index. Result channel
// (rsp_*): one result per request; tuser carries the status, tdata the
// entry page, its count and the number of entries in use.
// Config channel (csr_*): writes the region tag that new entries must match;
// always ready, write it only while no request is in flight.
// A record scans the table from slot 0 and stops at the first hit; a miss
// scans all TABLE_ENTRIES entries. A read passes through an address and a
// data state; clear and unused functions go straight to the result. The
// record time is set by the scan through the page and count memories, one
// entry per cycle through a single comparator and incrementer. One request
// is worked at a time; req_tready is high only while the engine is idle.
// A result waiting in the output register does not block the next request;
// a finished result waits in the engine only while that register is full
// and rsp_tready is low.
// Reset empties the table, sets the region tag to 0x4000 and drops any
// request and result in flight.
module page_access_histogram
   import pah_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // sample_address[63:0], slot_index[71:64]
   input  logic [FUNC_W-1:0]      req_tuser,  // func[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // entry_page[51:0], entry_count[83:52],
                                              // entries_used[92:84], zero[95:93]
   output logic [STAT_W-1:0]      rsp_tuser,  // op_status[2:0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TAG_W-1:0]       csr_data    // region_tag[31:0]
);

   logic [TAG_W-1:0]       region_tag_ff, region_tag_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [STAT_W-1:0]      rsp_tuser_ff, rsp_tuser_in;

   logic              cmd_vld;
   logic              cmd_rdy;
   cmd_type           cmd;
   logic              res_vld;
   res_type           res;
   logic [USED_W-1:0] used;
   logic              res_load;
   logic [ADDR_W-1:0] addr;

   assign addr          = req_tdata[ADDR_W-1:0];
   assign cmd.func      = func_type'(req_tuser);
   assign cmd.page      = PAGE_W'(addr >> PAGE_SHIFT_BITS);
   assign cmd.tag_match = (addr[ADDR_W-1:ADDR_W-TAG_W] == region_tag_ff);
   assign cmd.slot      = req_tdata[ADDR_W +: SLOT_W];

   assign req_tready = cmd_rdy;
   assign cmd_vld    = req_tvalid && cmd_rdy;
   assign csr_ready  = 1'b1;

   pah_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd_vld (cmd_vld),
      .cmd     (cmd),
      .cmd_rdy (cmd_rdy),
      .res_vld (res_vld),
      .res     (res),
      .used    (used),
      .res_ack (res_load)
   );

   // Load the output register when it is empty or being drained.
   assign res_load = res_vld && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      region_tag_in = region_tag_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (csr_valid) begin
         region_tag_in = csr_data;
      end
      if (res_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tuser_in  = res.status;
         rsp_tdata_in  = {{(RSP_TDATA_W - PAGE_W - COUNT_W - EUSED_W){1'b0}},
                          EUSED_W'(used), res.count, res.page};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_tag_ff <= TAG_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         region_tag_ff <= region_tag_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: test/tb_page_access_histogram.sv
`timescale 1ns / 1ps
module tb_page_access_histogram;
   import pah_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned BURST_ITEMS = 50;
   localparam int unsigned BURST_COUNT = 5;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [ADDR_W-1:0]  addr;
      logic [SLOT_W-1:0]  slot;
   } sample_req_type;

   typedef struct packed {
      status_type          status;
      logic [PAGE_W-1:0]   page;
      logic [COUNT_W-1:0]  count;
      logic [EUSED_W-1:0]  used;
   } histo_result_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]      rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [TAG_W-1:0]       csr_data   = '0;

   // Table mirror
   logic [PAGE_W-1:0]  mirror_page [TABLE_ENTRIES];
   logic [COUNT_W-1:0] mirror_count [TABLE_ENTRIES];
   bit                 mirror_live [TABLE_ENTRIES];
   int unsigned        mirror_used = 0;
   logic [TAG_W-1:0]   mirror_tag  = TAG_RESET;

   sample_req_type   sample_queue [$];
   histo_result_type awaited_results [$];
   sample_req_type   on_bus;
   logic          req_taken = 1'b0;
   logic          rsp_taken = 1'b0;
   int unsigned   send_gap = 0;
   int unsigned   sent_total = 0;
   int unsigned   stall_left = 0;
   int unsigned   drained_total = 0;
   int unsigned   mismatch_total = 0;
   logic [ADDR_W-1:0] fill_addrs [$];
   logic [ADDR_W-1:0] hot_addrs [$];

   page_access_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_address[63:0], slot_index[71:64]
      .req_tuser  (req_tuser),   // func[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // entry_page[51:0], entry_count[83:52], entries_used[92:84]
      .rsp_tuser  (rsp_tuser),   // op_status[2:0]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)     // region_tag[31:0]
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic histo_result_type tally_access(sample_req_type r);
      histo_result_type  res;
      logic [PAGE_W-1:0] pg;
      int                hit_slot;
      int                free_slot;
      res.status = ST_READ_EMPTY;
      res.page   = '0;
      res.count  = '0;
      hit_slot   = -1;
      free_slot  = -1;
      case (r.func)
         FUNC_RECORD: begin
            pg = PAGE_W'(r.addr >> PAGE_SHIFT_BITS);
            res.page = pg;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (mirror_live[i]) begin
                  if (hit_slot < 0 && mirror_page[i] == pg) hit_slot = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit_slot >= 0) begin
               if (mirror_count[hit_slot] != COUNT_MAX)
                  mirror_count[hit_slot] = mirror_count[hit_slot] + 1'b1;
               res.status = ST_HIT;
               res.count  = mirror_count[hit_slot];
            end else if (r.addr[ADDR_W-1 -: TAG_W] != mirror_tag) begin
               res.status = ST_FILTER;
            end else if (free_slot < 0) begin
               res.status = ST_FULL;
            end else begin
               mirror_live[free_slot]  = 1'b1;
               mirror_page[free_slot]  = pg;
               mirror_count[free_slot] = 1;
               mirror_used++;
               res.status = ST_INSERT;
               res.count  = 1;
            end
         end
         FUNC_READ: begin
            if (r.slot < TABLE_ENTRIES && mirror_live[r.slot]) begin
               res.status = ST_READ_VALID;
               res.page   = mirror_page[r.slot];
               res.count  = mirror_count[r.slot];
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) mirror_live[i] = 1'b0;
            mirror_used = 0;
            res.status  = ST_CLEARED;
         end
         default: ;
      endcase
      res.used = EUSED_W'(mirror_used);
      return res;
   endfunction

   function automatic sample_req_type make_req(logic [FUNC_W-1:0] func,
                                               logic [ADDR_W-1:0] addr,
                                               logic [SLOT_W-1:0] slot);
      sample_req_type r;
      r.func = func;
      r.addr = addr;
      r.slot = slot;
      return r;
   endfunction

   // Request driver: one item per transfer, random gap after each; none in every fourth run of 32.
   always @(negedge clock) begin : feed_requests
      logic hold;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         hold = req_tvalid;
         if (req_taken) begin
            awaited_results.push_back(tally_access(on_bus));
            sent_total++;
            send_gap = ((sent_total / 32) % 4 == 3) ? 0 : $urandom_range(0, 19);
            hold = 1'b0;
         end
         if (!hold) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (sample_queue.size() > 0) begin
               on_bus = sample_queue.pop_front();
               req_tdata <= {on_bus.slot, on_bus.addr};
               req_tuser <= on_bus.func;
               hold = 1'b1;
            end
         end
         req_tvalid <= hold;
      end
   end

   // Result backpressure: random ready-low stretch after each transfer; none in every third run of 40.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken)
            stall_left = ((drained_total / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_results
      histo_result_type want;
      logic [PAGE_W-1:0]  got_page;
      logic [COUNT_W-1:0] got_count;
      logic [EUSED_W-1:0] got_used;
      got_page  = rsp_tdata[PAGE_W-1:0];
      got_count = rsp_tdata[PAGE_W +: COUNT_W];
      got_used  = rsp_tdata[PAGE_W+COUNT_W +: EUSED_W];
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         drained_total++;
         if (awaited_results.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("unexpected result: status %0d page %h count %h used %0d",
                        rsp_tuser, got_page, got_count, got_used);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.status || got_page !== want.page ||
                got_count !== want.count || got_used !== want.used) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display({"mismatch: expected status %0d page %h count %h used %0d, ",
                            "got status %0d page %h count %h used %0d"},
                           want.status, want.page, want.count, want.used,
                           rsp_tuser, got_page, got_count, got_used);
            end
         end
      end
   end

   task automatic wait_drained;
      while (sample_queue.size() != 0 || req_tvalid || req_taken ||
             awaited_results.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic write_region_tag(input logic [TAG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      mirror_tag = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_burst(input int unsigned count);
      int unsigned roll;
      logic [ADDR_W-1:0] addr;
      logic [SLOT_W-1:0] slot;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         addr = {$urandom, $urandom};
         slot = SLOT_W'($urandom);
         if (roll < 50) begin
            // revisit a hot page at a random offset within it
            addr = hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
            addr[PAGE_SHIFT_BITS-1:0] = PAGE_SHIFT_BITS'($urandom);
            sample_queue.push_back(make_req(FUNC_RECORD, addr, slot));
         end else if (roll < 58) begin
            addr[ADDR_W-1 -: TAG_W] = mirror_tag;
            sample_queue.push_back(make_req(FUNC_RECORD, addr, slot));
         end else if (roll < 66) begin
            sample_queue.push_back(make_req(FUNC_RECORD, addr, slot));
         end else if (roll < 70) begin
            // tag off by one bit
            addr[ADDR_W-1 -: TAG_W] = mirror_tag ^ (32'h1 << $urandom_range(0, 31));
            sample_queue.push_back(make_req(FUNC_RECORD, addr, slot));
         end else if (roll < 92) begin
            sample_queue.push_back(make_req(FUNC_READ, addr, slot));
         end else if (roll < 96) begin
            sample_queue.push_back(make_req(FUNC_CLEAR, addr, slot));
         end else begin
            sample_queue.push_back(make_req(FUNC_UNUSED, addr, slot));
         end
      end
   endtask

   initial begin : run_phases
      logic [TAG_W-1:0]  fill_tag;
      logic [19:0]       base_page;
      logic [ADDR_W-1:0] addr;
      logic [TAG_W-1:0]  next_tag;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // reset tag, hits, filtering, read, clear, unused function
      sample_queue.push_back(make_req(FUNC_RECORD, {32'h0000_4000, 32'h0000_0000}, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, {32'h0000_4000, 32'h0000_0abc}, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, {32'h0000_4000, 32'hffff_ffff}, 8'hff));
      sample_queue.push_back(make_req(FUNC_RECORD, {32'h0000_4001, 32'h0000_1000}, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, 64'hffff_ffff_ffff_ffff, 8'hff));
      sample_queue.push_back(make_req(FUNC_RECORD, 64'h0, 8'h00));
      sample_queue.push_back(make_req(FUNC_UNUSED, {$urandom, $urandom}, 8'h00));
      sample_queue.push_back(make_req(FUNC_READ, 64'h0, 8'h00));
      sample_queue.push_back(make_req(FUNC_READ, 64'hffff_ffff_ffff_ffff, 8'h01));
      sample_queue.push_back(make_req(FUNC_CLEAR, 64'h0, 8'h00));
      sample_queue.push_back(make_req(FUNC_READ, 64'h0, 8'h01));
      sample_queue.push_back(make_req(FUNC_RECORD, {32'h0000_4000, 32'h0000_1000}, 8'h00));
      sample_queue.push_back(make_req(FUNC_READ, 64'h0, 8'h00));
      wait_drained();

      write_region_tag(32'hffff_ffff);
      sample_queue.push_back(make_req(FUNC_RECORD, 64'hffff_ffff_ffff_ffff, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, 64'hffff_ffff_ffff_f000, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, 64'h0, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, {32'h0000_4000, 32'h0000_1fff}, 8'h00));
      wait_drained();

      write_region_tag(32'h0);
      sample_queue.push_back(make_req(FUNC_RECORD, 64'h0, 8'h00));
      sample_queue.push_back(make_req(FUNC_RECORD, 64'h0000_0000_0000_0fff, 8'h00));
      sample_queue.push_back(make_req(FUNC_READ, 64'h0, 8'h02));
      sample_queue.push_back(make_req(FUNC_UNUSED, 64'hffff_ffff_ffff_ffff, 8'hff));
      wait_drained();

      // Fill every slot, then overflow, then hit on the full table.
      fill_tag = $urandom;
      write_region_tag(fill_tag);
      base_page = 20'($urandom_range(0, 20'hffc00));
      sample_queue.push_back(make_req(FUNC_CLEAR, {$urandom, $urandom}, SLOT_W'($urandom)));
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         addr = {fill_tag, base_page + 20'(i), 12'($urandom)};
         fill_addrs.push_back(addr);
         sample_queue.push_back(make_req(FUNC_RECORD, addr, SLOT_W'($urandom)));
      end
      for (int i = 0; i < 4; i++)
         sample_queue.push_back(make_req(FUNC_RECORD,
                                {fill_tag, base_page + 20'(TABLE_ENTRIES + 3 + i), 12'($urandom)},
                                SLOT_W'($urandom)));
      for (int i = 0; i < 3; i++)
         sample_queue.push_back(make_req(FUNC_RECORD,
                                fill_addrs[$urandom_range(0, TABLE_ENTRIES - 1)],
                                SLOT_W'($urandom)));
      wait_drained();

      for (int p = 0; p < BURST_COUNT; p++) begin
         hot_addrs.delete();
         if (p == 0) begin
            for (int i = 0; i < 12; i++)
               hot_addrs.push_back(fill_addrs[$urandom_range(0, TABLE_ENTRIES - 1)]);
         end else begin
            case (p)
               1: next_tag = 32'h0;
               2: next_tag = 32'hffff_ffff;
               3: next_tag = $urandom;
               default: next_tag = TAG_RESET;
            endcase
            write_region_tag(next_tag);
            for (int i = 0; i < 12; i++)
               hot_addrs.push_back({next_tag, $urandom});
         end
         push_burst(BURST_ITEMS);
         wait_drained();
      end

      repeat (300) @(posedge clock);
      #1;
      mismatch_total += awaited_results.size();
      if (mismatch_total == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
